// ===== rtl/core/arp_address_cache_top_assert.svh =====
// Assertion macros used by the ARP address cache sequencer.
`ifndef ARP_ADDRESS_CACHE_TOP_ASSERT_SVH
`define ARP_ADDRESS_CACHE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Checked property, masked while the active-low reset is asserted.
`define ARP_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked property that also holds during reset.
`define ARP_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ARP_ASSERT(name, clk, rstn, prop, msg)
`define ARP_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// ===== rtl/core/arp_pkg.sv =====
`default_nettype none

package arp_pkg;

    localparam int ENTRIES_DEFAULT = 8;
    localparam int IP_W            = 32;
    localparam int MAC_W           = 48;
    localparam int SLOT_W          = 3;

    typedef enum logic {
        KIND_LOOKUP = 1'b0,
        KIND_INSERT = 1'b1
    } arp_kind_t;

    typedef struct packed {
        arp_kind_t          kind;
        logic [IP_W-1:0]    ip_address;
        logic [MAC_W-1:0]   new_mac;
    } arp_req_t;

    typedef struct packed {
        logic               found;
        logic [MAC_W-1:0]   mac_out;
        logic [SLOT_W-1:0]  slot;
        logic               took_over;
    } arp_rsp_t;

    // One table entry as stored in the memory.
    typedef struct packed {
        logic [IP_W-1:0]    ip_address;
        logic [MAC_W-1:0]   mac;
    } arp_slot_t;

    // Strobes from the sequencer to the table.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } arp_tbl_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DECIDE
    } arp_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/arp_table.sv =====
`default_nettype none

module arp_table #(
    parameter int ENTRIES = arp_pkg::ENTRIES_DEFAULT,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  arp_pkg::arp_tbl_ctl_t tbl_ctl,
    input  wire  [IDX_W-1:0]     rd_idx,
    input  wire  [IDX_W-1:0]     wr_idx,
    input  arp_pkg::arp_slot_t   wr_data,
    output arp_pkg::arp_slot_t   rd_data,
    output logic                 rd_valid
);
    import arp_pkg::*;

    // Address and MAC storage; contents are meaningless until a slot is written.
    arp_slot_t          mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    arp_slot_t          rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (tbl_ctl.wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (tbl_ctl.rd_en) begin
            rd_data_reg  <= mem[rd_idx];
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (tbl_ctl.wr_en) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/arp_ctrl.sv =====
`default_nettype none
`include "arp_address_cache_top_assert.svh"

module arp_ctrl #(
    parameter int ENTRIES = arp_pkg::ENTRIES_DEFAULT,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  arp_pkg::arp_req_t     s_payload,
    output logic                  m_valid,
    input  wire                   m_ready,
    output arp_pkg::arp_rsp_t     m_payload,
    output arp_pkg::arp_tbl_ctl_t tbl_ctl,
    output logic [IDX_W-1:0]      rd_idx,
    output logic [IDX_W-1:0]      wr_idx,
    output arp_pkg::arp_slot_t    wr_data,
    input  arp_pkg::arp_slot_t    rd_data,
    input  wire                   rd_valid
);
    import arp_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    arp_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    arp_req_t          req_reg;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [MAC_W-1:0]  hit_mac_reg;
    logic              free_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic              m_valid_reg;
    arp_rsp_t          m_payload_reg;

    logic              accept;
    logic              out_free;
    logic              decide_fire;
    logic              cmp_match;
    logic              cmp_empty;
    arp_rsp_t          rsp;

    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign cmp_match   = cmp_vld_reg && rd_valid && (rd_data.ip_address == req_reg.ip_address);
    assign cmp_empty   = cmp_vld_reg && !rd_valid;

    // Next state.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_LAST;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_LAST: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_ready       = 1'b0;
        tbl_ctl.rd_en = 1'b0;
        tbl_ctl.wr_en = 1'b0;
        decide_fire   = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready       = 1'b1;
            ST_SCAN:   tbl_ctl.rd_en = 1'b1;
            ST_LAST:   ;
            ST_DECIDE: begin
                decide_fire   = out_free;
                tbl_ctl.wr_en = out_free && (req_reg.kind == KIND_INSERT);
            end
            default:   ;
        endcase
    end

    assign rd_idx             = cnt_reg;
    assign wr_data.ip_address = req_reg.ip_address;
    assign wr_data.mac        = req_reg.new_mac;

    // Write target and result of the finished scan.
    always_comb begin
        wr_idx        = '0;
        rsp.found     = hit_reg;
        rsp.mac_out   = '0;
        rsp.slot      = '0;
        rsp.took_over = 1'b0;
        priority if (req_reg.kind == KIND_LOOKUP) begin
            if (hit_reg) begin
                rsp.mac_out = hit_mac_reg;
                rsp.slot    = SLOT_W'(hit_idx_reg);
            end
        end else if (hit_reg) begin
            wr_idx   = hit_idx_reg;
            rsp.slot = SLOT_W'(hit_idx_reg);
        end else if (free_reg) begin
            wr_idx   = free_idx_reg;
            rsp.slot = SLOT_W'(free_idx_reg);
        end else begin
            rsp.took_over = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cmp_vld_reg <= tbl_ctl.rd_en;
            if (accept) begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end else begin
                if (cmp_match && !hit_reg) begin
                    hit_reg <= 1'b1;
                end
                if (cmp_empty && !free_reg) begin
                    free_reg <= 1'b1;
                end
            end
            if (decide_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_payload;
        end
        cmp_idx_reg <= rd_idx;
        if (cmp_match && !hit_reg) begin
            hit_idx_reg <= cmp_idx_reg;
            hit_mac_reg <= rd_data.mac;
        end
        if (cmp_empty && !free_reg) begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (decide_fire) begin
            m_payload_reg <= rsp;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    `ARP_ASSERT(a_accept_starts_scan, aclk, aresetn, accept |=> (state_reg == ST_SCAN && cnt_reg == '0), "accepted request did not start a scan at slot zero")
    `ARP_ASSERT(a_decide_loads_result, aclk, aresetn, decide_fire |=> m_valid_reg, "finished request did not present a result")
    `ARP_ASSERT(a_write_only_insert, aclk, aresetn, tbl_ctl.wr_en |-> (req_reg.kind == KIND_INSERT && state_reg == ST_DECIDE), "table written outside an insert decision")
    `ARP_ASSERT(a_takeover_is_miss, aclk, aresetn, m_valid_reg |-> !(m_payload_reg.took_over && m_payload_reg.found), "result reports both a hit and a takeover")
    `ARP_ASSERT_ALWAYS(a_no_read_write_overlap, aclk, !(tbl_ctl.rd_en && tbl_ctl.wr_en), "table read and written in the same cycle")

endmodule

`default_nettype wire

// ===== rtl/core/arp_address_cache_top.sv =====
`default_nettype none

// ARP address cache: a table of ENTRIES slots that maps IPv4 addresses to MAC
// addresses. Each request is a lookup or an insert. A lookup reports whether a
// valid slot holds the address and, on a hit, its MAC and slot number. An insert
// updates the MAC of a matching slot, otherwise fills the lowest free slot, and
// when the table is full overwrites slot 0 and flags the takeover. Requests are
// handled one at a time: a request is taken while the sequencer is idle, the
// sequencer then reads one slot per cycle from the read port of the entry memory
// (ST_SCAN), waits in ST_LAST for the read of the last slot, and in ST_DECIDE
// writes the table and loads the result register, waiting there while an earlier
// result is still unclaimed. The scan time is set by the memory read port, walked
// slot by slot. The result waits in its own register, so the next request is taken
// while an earlier result is still unclaimed. Slot numbers are reported in three
// bits, truncated when ENTRIES exceeds eight. Valid marks are cleared by reset;
// no clearing pass is needed.
module arp_address_cache_top #(
    parameter int ENTRIES = arp_pkg::ENTRIES_DEFAULT
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  arp_pkg::arp_req_t s_payload,
    output logic              m_valid,
    input  wire               m_ready,
    output arp_pkg::arp_rsp_t m_payload
);
    import arp_pkg::*;

    // Width of a slot index inside the table.
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    arp_tbl_ctl_t     tbl_ctl;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;
    arp_slot_t        wr_data;
    arp_slot_t        rd_data;
    logic             rd_valid;

    // The sequencer scans the table, picks the slot and builds the result.
    arp_ctrl #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .tbl_ctl   (tbl_ctl),
        .rd_idx    (rd_idx),
        .wr_idx    (wr_idx),
        .wr_data   (wr_data),
        .rd_data   (rd_data),
        .rd_valid  (rd_valid)
    );

    // The table holds address and MAC in memory and the valid marks in flops.
    arp_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tbl_ctl  (tbl_ctl),
        .rd_idx   (rd_idx),
        .wr_idx   (wr_idx),
        .wr_data  (wr_data),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

endmodule

`default_nettype wire
